>>> design/i2p_pkg.sv
// Shared types, character codes and precedence helpers for the infix to postfix converter.
// No dependencies.
`timescale 1ns / 1ps

package i2p_pkg;

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_MUL    = 8'h2A;
   localparam logic [7:0] CH_DIV    = 8'h2F;
   localparam logic [7:0] CH_POW    = 8'h5E;

   localparam logic [1:0] PREC_POW  = 2'd3;
   localparam logic [1:0] PREC_MUL  = 2'd2;
   localparam logic [1:0] PREC_ADD  = 2'd1;
   localparam logic [1:0] PREC_NONE = 2'd0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHAR,
      S_POP,
      S_LOAD,
      S_FLUSH,
      S_FINISH
   } i2p_state_type;

   // one result handed from the sequencer to the output register
   typedef struct packed {
      logic       load;
      logic [7:0] out_char;
      logic       char_valid;
      logic       run_last;
      logic       expr_done;
      logic       overflow;
   } i2p_emit_type;

   function automatic logic [1:0] prec_of(input logic [7:0] c);
      logic [1:0] p;
      p = PREC_NONE;
      if (c == CH_POW) begin
         p = PREC_POW;
      end else if (c == CH_MUL || c == CH_DIV) begin
         p = PREC_MUL;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
         p = PREC_ADD;
      end
      return p;
   endfunction

   function automatic logic is_oper(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_MUL) ||
             (c == CH_DIV) || (c == CH_POW);
   endfunction

endpackage

>>> design/i2p_stack_mem.sv
// Operator stack storage: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module i2p_stack_mem #(
   parameter int STACK_DEPTH = 32,
   parameter int AW          = $clog2(STACK_DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [STACK_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/i2p_ctrl.sv
// Sequencer for the converter: stack pointer, overflow flag, pending result and stack accesses.
// Depends on i2p_pkg; drives i2p_stack_mem and the output register in the top level.
`timescale 1ns / 1ps

module i2p_ctrl
   import i2p_pkg::*;
#(
   parameter int STACK_DEPTH = 32,
   parameter int AW          = $clog2(STACK_DEPTH),
   parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [7:0]    req_in_char,
   input  logic          req_end_of_expr,
   output logic          req_stall,
   input  logic          out_free,
   output i2p_emit_type  emit,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   input  logic [7:0]    rd_data
);

   localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

   i2p_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    char_ff, char_in;
   logic          end_ff, end_in;
   logic          pend_vld_ff, pend_vld_in;
   logic [7:0]    pend_char_ff, pend_char_in;

   logic [CW-1:0] count_m1;
   logic [CW-1:0] count_m2;
   logic          full;
   logic          can_produce;
   logic          is_close;
   i2p_state_type after_item;

   assign count_m1    = count_ff - CW'(1);
   assign count_m2    = count_ff - CW'(2);
   assign full        = (count_ff == FULL_COUNT);
   assign can_produce = !pend_vld_ff || out_free;
   assign is_close    = (char_ff == CH_RPAREN);
   assign after_item  = end_ff ? S_LOAD : S_FINISH;
   assign req_stall   = (state_ff != S_IDLE);

   always_comb begin
      logic       do_prod;
      logic [7:0] prod_char;
      logic       do_push;

      do_prod   = 1'b0;
      prod_char = rd_data;
      do_push   = 1'b0;

      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      char_in      = char_ff;
      end_in       = end_ff;
      pend_vld_in  = pend_vld_ff;
      pend_char_in = pend_char_ff;

      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = char_ff;
      rd_en   = 1'b0;
      rd_addr = count_m1[AW-1:0];
      emit    = '0;

      unique case (state_ff)
         S_IDLE: begin
            wr_data = req_in_char;
            if (req_valid) begin
               char_in = req_in_char;
               end_in  = req_end_of_expr;
               if (req_in_char == CH_LPAREN) begin
                  do_push  = 1'b1;
                  state_in = req_end_of_expr ? S_LOAD : S_IDLE;
               end else if (req_in_char == CH_RPAREN || is_oper(req_in_char)) begin
                  rd_en    = 1'b1;
                  state_in = S_POP;
               end else begin
                  state_in = S_CHAR;
               end
            end
         end
         S_CHAR: begin
            if (can_produce) begin
               do_prod   = 1'b1;
               prod_char = char_ff;
               state_in  = after_item;
            end
         end
         S_POP: begin
            // rd_data holds the current top of stack
            if (count_ff == '0) begin
               do_push  = !is_close;
               state_in = after_item;
            end else if (is_close && rd_data == CH_LPAREN) begin
               count_in = count_m1;
               state_in = after_item;
            end else if (is_close || prec_of(rd_data) >= prec_of(char_ff)) begin
               if (can_produce) begin
                  do_prod  = 1'b1;
                  count_in = count_m1;
                  rd_en    = 1'b1;
                  rd_addr  = count_m2[AW-1:0];
               end
            end else begin
               do_push  = 1'b1;
               state_in = after_item;
            end
         end
         S_LOAD: begin
            rd_en    = 1'b1;
            state_in = S_FLUSH;
         end
         S_FLUSH: begin
            if (count_ff == '0) begin
               state_in = S_FINISH;
            end else if (can_produce) begin
               do_prod  = 1'b1;
               count_in = count_m1;
               rd_en    = 1'b1;
               rd_addr  = count_m2[AW-1:0];
            end
         end
         S_FINISH: begin
            if (!pend_vld_ff && !end_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               emit.load       = 1'b1;
               emit.out_char   = pend_vld_ff ? pend_char_ff : 8'h00;
               emit.char_valid = pend_vld_ff;
               emit.run_last   = 1'b1;
               emit.expr_done  = end_ff;
               emit.overflow   = ovf_ff;
               pend_vld_in     = 1'b0;
               if (end_ff) begin
                  ovf_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_push) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end
      end

      // the previous result leaves only once it is known not to be the last
      if (do_prod) begin
         if (pend_vld_ff) begin
            emit.load       = 1'b1;
            emit.out_char   = pend_char_ff;
            emit.char_valid = 1'b1;
            emit.overflow   = ovf_ff;
         end
         pend_vld_in  = 1'b1;
         pend_char_in = prod_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      end_ff       <= end_in;
      pend_char_ff <= pend_char_in;
   end

endmodule

>>> design/infix_to_postfix_converter.sv
// Channel  | Direction | Ports                                   | Transaction
// req      | in        | req_valid, req_stall, req_in_char,      | one infix character
//          |           | req_end_of_expr                         |
// rsp      | out       | rsp_valid, rsp_stall, rsp_out_char,     | one postfix result
//          |           | rsp_char_valid, rsp_run_last,           |
//          |           | rsp_expr_done, rsp_overflow             |
//
// One transaction at a time; req_stall is high from acceptance until its last result
// is in the output register. A '(' without end is taken without a stall; an operator
// or ')' pops stack entries one at a time through the registered read data of the
// stack memory, and an end transaction then flushes the stack through S_LOAD and
// S_FLUSH. No clearing pass after reset: stack entries above the pointer go unused.
// A stalled rsp side holds the sequencer only where a result must enter a full output
// register. Depends on i2p_pkg, i2p_stack_mem and i2p_ctrl.
`timescale 1ns / 1ps

module infix_to_postfix_converter
   import i2p_pkg::*;
#(
   parameter int STACK_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_end_of_expr,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_run_last,
   output logic       rsp_expr_done,
   output logic       rsp_overflow
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   i2p_emit_type  emit;
   logic          out_free;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   logic          rsp_valid_ff, rsp_valid_in;
   i2p_emit_type  rsp_ff, rsp_in;

   i2p_ctrl #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW),
      .CW          (CW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_in_char     (req_in_char),
      .req_end_of_expr (req_end_of_expr),
      .req_stall       (req_stall),
      .out_free        (out_free),
      .emit            (emit),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   i2p_stack_mem #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit.load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = rsp_ff.out_char;
   assign rsp_char_valid = rsp_ff.char_valid;
   assign rsp_run_last   = rsp_ff.run_last;
   assign rsp_expr_done  = rsp_ff.expr_done;
   assign rsp_overflow   = rsp_ff.overflow;

endmodule
